/* design/aes_cbc_pkg.sv */
`default_nettype none
package aes_cbc_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int KEY_ENTRIES = NUM_ROUNDS + 1;
    localparam int KIDX_W = 4;

    typedef enum logic [2:0] {
        CFG_KEY_HIGH  = 3'd0,
        CFG_KEY_LOW   = 3'd1,
        CFG_IV_HIGH   = 3'd2,
        CFG_IV_LOW    = 3'd3,
        CFG_DIRECTION = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  byte_count;
        logic        last_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  valid_bytes;
        logic        last_result;
        logic        pad_error;
    } t_out_item;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        get_byte = s[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // one forward round: sub bytes, shift rows, optional mix columns, add key
    function automatic logic [127:0] enc_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         final_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) & 3))];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!final_rnd) begin
                t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        enc_round = r ^ rk;
    endfunction

    // one inverse round: inv shift rows, inv sub bytes, add key, optional inv mix
    function automatic logic [127:0] dec_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         final_rnd);
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [7:0] m2, m4, m8;
        logic [7:0] g9 [4];
        logic [7:0] g11 [4];
        logic [7:0] g13 [4];
        logic [7:0] g14 [4];
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*((c + i) & 3)] = INV_SBOX[get_byte(s, i + 4*c)] ^
                                         get_byte(rk, i + 4*((c + i) & 3));
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j] = t[4*c + j];
                m2 = xtime(a[j]);
                m4 = xtime(m2);
                m8 = xtime(m4);
                g9[j]  = m8 ^ a[j];
                g11[j] = m8 ^ m2 ^ a[j];
                g13[j] = m8 ^ m4 ^ a[j];
                g14[j] = m8 ^ m4 ^ m2;
            end
            if (!final_rnd) begin
                t[4*c]   = g14[0] ^ g11[1] ^ g13[2] ^ g9[3];
                t[4*c+1] = g9[0] ^ g14[1] ^ g11[2] ^ g13[3];
                t[4*c+2] = g13[0] ^ g9[1] ^ g14[2] ^ g11[3];
                t[4*c+3] = g11[0] ^ g13[1] ^ g9[2] ^ g14[3];
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        dec_round = r;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0]   rc);
        logic [31:0] w [4];
        logic [31:0] t;
        for (int i = 0; i < 4; i++) begin
            w[i] = k[127 - 32*i -: 32];
        end
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        next_round_key = {w[0], w[1], w[2], w[3]};
    endfunction

endpackage
`default_nettype wire

/* design/aes128_cbc_cipher_core.sv */
`default_nettype none
// channel   signals                        direction
// input     i_valid, o_ready, i_in         block in, accepted on valid and ready
// output    o_valid, i_ready, o_out        result out, taken on valid and ready
// config    i_cfg_we, i_cfg_idx, i_cfg_data  register write, no wait
//
// an item runs through accept, key prefetch, 11 add-key/round steps
// through the single round unit, then the result lands in the output register
// a full last encrypt block runs a second pass for the padding block
// the round key memory is read once per cycle into a registered output
// reset and every key write run the key expansion, then a settle state,
// before items are accepted; a stalled output holds the next result back
module aes128_cbc_cipher_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  aes_cbc_pkg::t_in_item  i_in,
    output logic                   o_valid,
    input  wire                    i_ready,
    output aes_cbc_pkg::t_out_item o_out,
    input  wire                    i_cfg_we,
    input  wire  [2:0]             i_cfg_idx,
    input  wire  [63:0]            i_cfg_data
);
    import aes_cbc_pkg::*;

    typedef enum logic [5:0] {
        ST_EXP  = 6'b000001,
        ST_WAIT = 6'b000010,
        ST_IDLE = 6'b000100,
        ST_KEY  = 6'b001000,
        ST_RUN  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [63:0]  r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic         r_dir;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_kw, n_kw;
    logic [KIDX_W-1:0] r_kidx, n_kidx;
    logic [KIDX_W-1:0] r_step, n_step;
    logic [127:0] r_blk, n_blk;
    logic [127:0] r_cin, n_cin;
    logic         r_dec, n_dec;
    logic         r_last, n_last;
    logic         r_extra, n_extra;
    logic         r_ovalid, n_ovalid;
    t_out_item    r_out, n_out;

    logic [127:0] key_mem [KEY_ENTRIES];
    logic [127:0] r_rk;
    logic [KIDX_W-1:0] raddr;
    logic         kwe;

    logic [127:0] in_blk, pt, step_res;
    logic [4:0]   nsat;
    logic [7:0]   pad_v, padb;
    logic         pad_ok, out_free;

    assign kwe = (r_state == ST_EXP);

    always_ff @(posedge i_clk) begin
        if (kwe) begin
            key_mem[r_kidx] <= r_kw;
        end
        r_rk <= key_mem[raddr];
    end

    // address for the step that runs in the next cycle
    always_comb begin
        raddr = '0;
        if (r_state == ST_KEY) begin
            raddr = r_dec ? KIDX_W'(NUM_ROUNDS) : '0;
        end else if (r_state == ST_RUN && r_step < KIDX_W'(NUM_ROUNDS)) begin
            raddr = r_dec ? KIDX_W'(NUM_ROUNDS - 1) - r_step : r_step + 1'b1;
        end
    end

    always_comb begin
        if (r_step == '0) begin
            step_res = r_blk ^ r_rk;
        end else if (r_dec) begin
            step_res = dec_round(r_blk, r_rk, r_step == KIDX_W'(NUM_ROUNDS));
        end else begin
            step_res = enc_round(r_blk, r_rk, r_step == KIDX_W'(NUM_ROUNDS));
        end
    end

    // input block with padding applied for a short last encrypt block
    always_comb begin
        nsat = (i_in.byte_count > 5'd16) ? 5'd16 : i_in.byte_count;
        padb = 8'(5'd16 - nsat);
        in_blk = {i_in.block_high, i_in.block_low};
        if (i_in.last_block) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) >= nsat) begin
                    in_blk[127 - 8*i -: 8] = padb;
                end
            end
        end
    end

    always_comb begin
        pt = r_blk ^ r_chain;
        pad_v = pt[7:0];
        pad_ok = (pad_v >= 8'd1) && (pad_v <= 8'd16);
        for (int i = 0; i < 16; i++) begin
            if ((9'(i) >= 9'd16 - {1'b0, pad_v}) && (pt[127 - 8*i -: 8] != pad_v)) begin
                pad_ok = 1'b0;
            end
        end
    end

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_ovalid;
    assign o_out    = r_out;

    always_comb begin
        n_state  = r_state;
        n_kw     = r_kw;
        n_kidx   = r_kidx;
        n_step   = r_step;
        n_blk    = r_blk;
        n_cin    = r_cin;
        n_dec    = r_dec;
        n_last   = r_last;
        n_extra  = r_extra;
        n_chain  = r_chain;
        n_ovalid = r_ovalid && !i_ready;
        n_out    = r_out;

        unique case (r_state)
            ST_EXP: begin
                // the last expansion step has no round constant left
                n_kw   = next_round_key(r_kw, (r_kidx < KIDX_W'(NUM_ROUNDS)) ?
                                              RCON[r_kidx] : 8'h00);
                n_kidx = r_kidx + 1'b1;
                if (r_kidx == KIDX_W'(NUM_ROUNDS)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_dec   = r_dir;
                    n_last  = i_in.last_block;
                    n_cin   = {i_in.block_high, i_in.block_low};
                    n_extra = !r_dir && i_in.last_block && (nsat == 5'd16);
                    n_blk   = r_dir ? n_cin : in_blk ^ r_chain;
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                n_step  = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                n_blk  = step_res;
                n_step = r_step + 1'b1;
                if (r_step == KIDX_W'(NUM_ROUNDS)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out.pad_error   = 1'b0;
                    n_out.valid_bytes = 5'd16;
                    n_out.last_result = r_last && !r_extra;
                    n_state = ST_IDLE;
                    if (r_dec) begin
                        {n_out.out_high, n_out.out_low} = pt;
                        if (r_last && pad_ok) begin
                            n_out.valid_bytes = 5'(9'd16 - {1'b0, pad_v});
                        end
                        n_out.pad_error = r_last && !pad_ok;
                        n_chain = r_last ? {r_iv_hi, r_iv_lo} : r_cin;
                    end else begin
                        {n_out.out_high, n_out.out_low} = r_blk;
                        n_chain = r_blk;
                        if (r_extra) begin
                            n_extra = 1'b0;
                            n_blk   = {16{8'h10}} ^ r_blk;
                            n_state = ST_KEY;
                        end else if (r_last) begin
                            n_chain = {r_iv_hi, r_iv_lo};
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH: begin
                    n_kw    = {i_cfg_data, r_key_lo};
                    n_kidx  = '0;
                    n_state = ST_EXP;
                end
                CFG_KEY_LOW: begin
                    n_kw    = {r_key_hi, i_cfg_data};
                    n_kidx  = '0;
                    n_state = ST_EXP;
                end
                CFG_IV_HIGH: n_chain[127:64] = i_cfg_data;
                CFG_IV_LOW:  n_chain[63:0]   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_EXP;
            r_kidx   <= '0;
            r_kw     <= '0;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_iv_hi  <= '0;
            r_iv_lo  <= '0;
            r_dir    <= 1'b0;
            r_chain  <= '0;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_extra  <= 1'b0;
            r_dec    <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kidx   <= n_kidx;
            r_kw     <= n_kw;
            r_chain  <= n_chain;
            r_ovalid <= n_ovalid;
            r_step   <= n_step;
            r_extra  <= n_extra;
            r_dec    <= n_dec;
            r_last   <= n_last;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY_HIGH:  r_key_hi <= i_cfg_data;
                    CFG_KEY_LOW:   r_key_lo <= i_cfg_data;
                    CFG_IV_HIGH:   r_iv_hi  <= i_cfg_data;
                    CFG_IV_LOW:    r_iv_lo  <= i_cfg_data;
                    CFG_DIRECTION: r_dir    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_cin <= n_cin;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_step <= KIDX_W'(NUM_ROUNDS)))
        else $error("round step out of range");
    a_exp_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXP && r_kidx == KIDX_W'(NUM_ROUNDS) && !i_cfg_we)
        |=> (r_state == ST_WAIT))
        else $error("key expansion did not settle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_out)))
        else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

/* dv/tb.sv */
module tb;
    import aes_cbc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    aes128_cbc_cipher_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // cipher state mirrored in the testbench
    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         dir_dec;
    logic [127:0] chain_blk;
    logic [127:0] rkeys [11];

    t_in_item  pending_blocks [$];
    t_out_item expected_results [$];
    int        error_count = 0;
    longint    cycle_count = 0;
    bit        calm = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    function automatic void add_block(input t_in_item it);
        pending_blocks = {pending_blocks, it};
    endfunction

    function automatic void add_expected(input t_out_item r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [7:0] sb(input logic [7:0] v);
        logic [7:0] inv, p, q, r;
        // sbox from the field inverse and affine map
        inv = 8'h00;
        for (int c = 1; c < 256; c++) begin
            p = 8'h00; q = v; r = c[7:0];
            for (int k = 0; k < 8; k++) begin
                if (r[0]) p ^= q;
                q = {q[6:0], 1'b0} ^ (q[7] ? 8'h1b : 8'h00);
                r = r >> 1;
            end
            if (p == 8'h01) inv = c[7:0];
        end
        for (int k = 0; k < 8; k++)
            p[k] = inv[k] ^ inv[(k+4)%8] ^ inv[(k+5)%8] ^ inv[(k+6)%8] ^ inv[(k+7)%8];
        return p ^ 8'h63;
    endfunction

    logic [7:0] fsb [256];
    logic [7:0] isb [256];

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] bt(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic void expand_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [127:0] k;
        k = {key_hi, key_lo};
        for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fsb[t[31:24]] ^ rc, fsb[t[23:16]], fsb[t[15:8]], fsb[t[7:0]]};
                rc = gm(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic logic [127:0] aes_enc(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = bt(blk ^ rkeys[0], i);
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) s[i] = fsb[s[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i)%4)];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    s[4*c+i] = (r == 10) ? t[4*c+i] :
                        gm(t[4*c+i], 2) ^ gm(t[4*c+(i+1)%4], 3) ^
                        t[4*c+(i+2)%4] ^ t[4*c+(i+3)%4];
            for (int i = 0; i < 16; i++) s[i] ^= bt(rkeys[r], i);
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    function automatic logic [127:0] aes_dec(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = bt(blk ^ rkeys[10], i);
        for (int r = 9; r >= 0; r--) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[i + 4*((c+i)%4)] = s[i+4*c];
            for (int i = 0; i < 16; i++) t[i] = isb[t[i]] ^ bt(rkeys[r], i);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    s[4*c+i] = (r == 0) ? t[4*c+i] :
                        gm(t[4*c+i], 14) ^ gm(t[4*c+(i+1)%4], 11) ^
                        gm(t[4*c+(i+2)%4], 13) ^ gm(t[4*c+(i+3)%4], 9);
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    function automatic t_out_item mk(input logic [127:0] b, input logic [4:0] vb,
                                     input logic lst, input logic err);
        t_out_item r;
        r.out_high = b[127:64]; r.out_low = b[63:0];
        r.valid_bytes = vb; r.last_result = lst; r.pad_error = err;
        return r;
    endfunction

    function automatic void predict_cbc(input t_in_item it);
        logic [127:0] b, p;
        logic [4:0]   n;
        logic [7:0]   pv;
        bit           ok;
        b = {it.block_high, it.block_low};
        if (!dir_dec) begin
            if (!it.last_block) begin
                chain_blk = aes_enc(b ^ chain_blk);
                add_expected(mk(chain_blk, 5'd16, 1'b0, 1'b0));
            end else begin
                n = (it.byte_count > 16) ? 5'd16 : it.byte_count;
                if (n < 16) begin
                    for (int i = 0; i < 16; i++)
                        if (i >= n) b[127-8*i -: 8] = 8'(16 - n);
                    chain_blk = aes_enc(b ^ chain_blk);
                    add_expected(mk(chain_blk, 5'd16, 1'b1, 1'b0));
                end else begin
                    chain_blk = aes_enc(b ^ chain_blk);
                    add_expected(mk(chain_blk, 5'd16, 1'b0, 1'b0));
                    chain_blk = aes_enc({16{8'h10}} ^ chain_blk);
                    add_expected(mk(chain_blk, 5'd16, 1'b1, 1'b0));
                end
                chain_blk = {iv_hi, iv_lo};
            end
        end else begin
            p = aes_dec(b) ^ chain_blk;
            if (!it.last_block) begin
                chain_blk = b;
                add_expected(mk(p, 5'd16, 1'b0, 1'b0));
            end else begin
                pv = p[7:0];
                ok = (pv >= 1 && pv <= 16);
                if (ok)
                    for (int i = 16 - pv; i < 16; i++)
                        if (bt(p, i) != pv) ok = 0;
                add_expected(ok ? mk(p, 5'(16 - pv), 1'b1, 1'b0)
                                : mk(p, 5'd16, 1'b1, 1'b1));
                chain_blk = {iv_hi, iv_lo};
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // block driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_cbc(i_in);
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_blocks.size() > 0 &&
                             !(i_valid && o_ready && 0)) begin
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(1, 7) - 1;
                        i_valid <= 1'b0;
                    end else begin
                        i_in <= pending_blocks.pop_front();
                        i_valid <= 1'b1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (o_out.out_high !== e.out_high)
                        report_mismatch($sformatf("out_high %h exp %h", o_out.out_high, e.out_high));
                    if (o_out.out_low !== e.out_low)
                        report_mismatch($sformatf("out_low %h exp %h", o_out.out_low, e.out_low));
                    if (o_out.valid_bytes !== e.valid_bytes)
                        report_mismatch($sformatf("valid_bytes %0d exp %0d",
                                                  o_out.valid_bytes, e.valid_bytes));
                    if (o_out.last_result !== e.last_result)
                        report_mismatch("last_result");
                    if (o_out.pad_error !== e.pad_error)
                        report_mismatch("pad_error");
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 7) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_HIGH: begin key_hi = val; expand_keys(); end
            CFG_KEY_LOW: begin key_lo = val; expand_keys(); end
            CFG_IV_HIGH: begin iv_hi = val; chain_blk[127:64] = val; end
            CFG_IV_LOW: begin iv_lo = val; chain_blk[63:0] = val; end
            CFG_DIRECTION: dir_dec = val[0];
            default: ;
        endcase
    endtask

    function automatic t_in_item blk(input logic [127:0] b, input logic [4:0] n,
                                     input logic lst);
        t_in_item it;
        it.block_high = b[127:64]; it.block_low = b[63:0];
        it.byte_count = n; it.last_block = lst;
        return it;
    endfunction

    function automatic logic [127:0] rnd128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // wait for drain, then enough cycles for a whole pass plus key expansion
    task automatic drain();
        while (pending_blocks.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // random message; in decrypt mode mostly genuine ciphertext of padded text
    task automatic queue_message(input int len);
        logic [127:0] c, p, iv;
        int           n;
        if (!dir_dec || $urandom_range(0, 3) == 0) begin
            for (int k = 0; k < len; k++)
                add_block(blk(rnd128(), 5'($urandom_range(0, 31)), k == len - 1));
        end else begin
            // build ciphertext with a local chain so padding checks mostly pass
            iv = {iv_hi, iv_lo};
            c = iv;
            for (int k = 0; k < len; k++) begin
                p = rnd128();
                if (k == len - 1) begin
                    n = $urandom_range(1, 16);
                    for (int i = 16 - n; i < 16; i++) p[127-8*i -: 8] = 8'(n);
                    if ($urandom_range(0, 4) == 0) p[8*$urandom_range(0, 15) +: 8] ^= 8'h04;
                end
                c = aes_enc(p ^ c);
                add_block(blk(c, 5'($urandom_range(0, 31)), k == len - 1));
            end
        end
    endtask

    initial begin
        int sent;
        for (int v = 0; v < 256; v++) fsb[v] = sb(v[7:0]);
        for (int v = 0; v < 256; v++) isb[fsb[v]] = v[7:0];
        key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0; dir_dec = 1'b0;
        chain_blk = '0;
        expand_keys();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);

        // directed: reset key, field extremes and byte counts
        add_block(blk('0, 5'd0, 1'b0));
        add_block(blk('1, 5'd31, 1'b0));
        add_block(blk('1, 5'd0, 1'b1));
        add_block(blk(rnd128(), 5'd16, 1'b1));
        add_block(blk(rnd128(), 5'd17, 1'b1));
        add_block(blk(rnd128(), 5'd31, 1'b1));
        add_block(blk(rnd128(), 5'd1, 1'b1));
        add_block(blk(rnd128(), 5'd15, 1'b1));
        drain();
        cfg_write(CFG_KEY_HIGH, '1);
        cfg_write(CFG_KEY_LOW, '1);
        cfg_write(CFG_IV_HIGH, '1);
        cfg_write(CFG_IV_LOW, '1);
        add_block(blk(rnd128(), 5'd7, 1'b1));
        drain();
        cfg_write(CFG_DIRECTION, 64'd1);
        queue_message(1);
        queue_message(3);
        add_block(blk('0, 5'd0, 1'b1));
        add_block(blk('1, 5'd0, 1'b1));
        drain();
        // key change and direction change in the middle of a message
        add_block(blk(rnd128(), 5'd0, 1'b0));
        drain();
        cfg_write(CFG_KEY_LOW, 64'h0123456789abcdef);
        cfg_write(CFG_DIRECTION, 64'd0);
        add_block(blk(rnd128(), 5'd5, 1'b1));
        drain();

        sent = 0;
        while (sent < 540) begin
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(CFG_KEY_HIGH, {$urandom, $urandom});
                cfg_write(CFG_KEY_LOW, {$urandom, $urandom});
                cfg_write(CFG_IV_HIGH, {$urandom, $urandom});
                cfg_write(CFG_IV_LOW, {$urandom, $urandom});
            end
            cfg_write(CFG_DIRECTION, 64'($urandom_range(0, 1)));
            if (sent > 460) calm = 1'b1;
            for (int m = 0; m < 4; m++) begin
                int len;
                len = $urandom_range(1, 6);
                queue_message(len);
                sent += len;
            end
            drain();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
design/aes_cbc_pkg.sv
design/aes128_cbc_cipher_core.sv
dv/tb.sv
